[rtl/tzec_pkg.sv]
`default_nettype none

package tzec_pkg;

    // Field widths fixed by the panel interface.
    localparam int RAW_W = 12;
    localparam int ROW_W = 8;
    localparam int HOLD_W = 16;
    localparam int TIME_W = 32;
    localparam int EV_W = 3;
    localparam int SX_W = 9;
    localparam int SY_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Event codes.
    localparam logic [EV_W-1:0] EV_NONE = 3'd0;
    localparam logic [EV_W-1:0] EV_PREV = 3'd1;
    localparam logic [EV_W-1:0] EV_SELECT = 3'd2;
    localparam logic [EV_W-1:0] EV_NEXT = 3'd3;
    localparam logic [EV_W-1:0] EV_BACK = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CAL_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_MAX_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_MIN_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_MAX_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FOOTER_TOP_ROW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_ROWS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_MS = 3'd6;

    // Calibration window defaults and the minimum usable span.
    localparam logic [RAW_W-1:0] DEF_CAL_MIN = 12'd200;
    localparam logic [RAW_W-1:0] DEF_CAL_MAX = 12'd3800;
    localparam logic [RAW_W-1:0] CAL_MIN_SPAN = 12'd200;

    // Reset values of the remaining registers.
    localparam logic [ROW_W-1:0] DEF_FOOTER_TOP_ROW = 8'd210;
    localparam logic [ROW_W-1:0] DEF_HEADER_ROWS = 8'd30;
    localparam logic [HOLD_W-1:0] DEF_HOLDOFF_MS = 16'd90;

    // Zone boundaries in screen columns.
    localparam logic [7:0] ZONE_PREV_END = 8'd106;
    localparam logic [7:0] ZONE_SEL_END = 8'd213;
    localparam logic [7:0] BACK_COL_END = 8'd60;

endpackage

`default_nettype wire

[rtl/tzec_div.sv]
`default_nettype none

// Restoring divider that retires one quotient bit per cycle.
module tzec_div
    import tzec_pkg::*;
#(
    parameter int NUM_W = 21
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] numer,
    input  wire logic [RAW_W-1:0] denom,
    output logic                  done,
    output logic [NUM_W-1:0]      quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] shift_reg;
    logic [RAW_W-1:0] rem_reg;
    logic [RAW_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [RAW_W:0]   rem_shift;
    logic             fits;
    logic [RAW_W:0]   rem_sub;

    // One trial subtraction of the divisor from the shifted remainder.
    always_comb
    begin
        rem_shift = {rem_reg, shift_reg[NUM_W-1]};
        fits = (rem_shift >= {1'b0, den_reg});
        rem_sub = rem_shift - {1'b0, den_reg};
    end

    // Shift register holds the remaining numerator bits and collects quotient bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
            shift_reg <= '0;
            rem_reg <= '0;
            den_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CNT_W'(NUM_W);
                shift_reg <= numer;
                rem_reg <= '0;
                den_reg <= denom;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? rem_sub[RAW_W-1:0] : rem_shift[RAW_W-1:0];
                shift_reg <= {shift_reg[NUM_W-2:0], fits};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = shift_reg;

endmodule

`default_nettype wire

[rtl/touch_zone_event_classifier.sv]
`default_nettype none

// Touch zone event classifier. Each input transaction is one touch-panel sample
// and produces exactly one output transaction. A sample without contact, a held
// press or a press inside the hold-off time is answered with event 0 and a zero
// point, registered in the cycle after the sample is taken. An accepted press
// is mapped through the calibration window, or the default window when a span
// is too narrow, onto the screen by one shared serial divider, first for X and
// then for Y; the divider retires one quotient bit per cycle. The block takes
// no new sample while a press is being mapped. Configuration writes are taken
// at any time the block is idle, and a write to any calibration register
// clears the press latch.
module touch_zone_event_classifier
    import tzec_pkg::*;
#(
    parameter int SCREEN_MAX_X = 319,
    parameter int SCREEN_MAX_Y = 239
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  touched,
    input  wire logic [RAW_W-1:0]      raw_x,
    input  wire logic [RAW_W-1:0]      raw_y,
    input  wire logic [TIME_W-1:0]     now_ms,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [EV_W-1:0]            event_res,
    output logic [SX_W-1:0]            screen_x,
    output logic [SY_W-1:0]            screen_y
);

    localparam int XW = $clog2(SCREEN_MAX_X + 1);
    localparam int YW = $clog2(SCREEN_MAX_Y + 1);
    localparam int TW = (XW > YW) ? XW : YW;
    localparam int NUM_W = RAW_W + TW;
    localparam int CW = (TW > 8) ? TW : 8;
    localparam logic [TW-1:0] TOP_X = TW'(SCREEN_MAX_X);
    localparam logic [TW-1:0] TOP_Y = TW'(SCREEN_MAX_Y);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAP,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic              axis_reg;

    logic [RAW_W-1:0]  cal_min_x_reg;
    logic [RAW_W-1:0]  cal_max_x_reg;
    logic [RAW_W-1:0]  cal_min_y_reg;
    logic [RAW_W-1:0]  cal_max_y_reg;
    logic [ROW_W-1:0]  footer_top_row_reg;
    logic [ROW_W-1:0]  header_rows_reg;
    logic [HOLD_W-1:0] holdoff_ms_reg;

    logic              press_latched_reg;
    logic [TIME_W-1:0] last_event_time_reg;

    logic [RAW_W-1:0]  raw_x_reg;
    logic [RAW_W-1:0]  raw_y_reg;
    logic [XW-1:0]     x_reg;
    logic [YW-1:0]     y_reg;

    logic              out_valid_reg;
    logic [EV_W-1:0]   event_res_reg;
    logic [SX_W-1:0]   screen_x_reg;
    logic [SY_W-1:0]   screen_y_reg;

    logic              out_free;
    logic              in_accept;
    logic [TIME_W-1:0] elapsed;
    logic              press_ok;
    logic              win_ok;
    logic [RAW_W-1:0]  lo_sel;
    logic [RAW_W-1:0]  hi_sel;
    logic [RAW_W-1:0]  raw_sel;
    logic [TW-1:0]     top_sel;
    logic              below_win;
    logic [NUM_W-1:0]  product;
    logic [RAW_W-1:0]  span;
    logic              div_start;
    logic              div_done;
    logic [NUM_W-1:0]  div_quot;
    logic [TW-1:0]     quot_clamped;
    logic [EV_W-1:0]   ev_class;

    // Handshake: a sample is taken only when idle and the result slot frees up.
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == ST_IDLE) && out_free);
    assign in_accept = in_valid && !in_stall;

    // Press qualification with wrapping elapsed time.
    always_comb
    begin
        elapsed = now_ms - last_event_time_reg;
        press_ok = !press_latched_reg && (elapsed >= TIME_W'(holdoff_ms_reg));
    end

    // Calibration window selection and operands for the current axis.
    always_comb
    begin
        win_ok = ((RAW_W + 1)'(cal_min_x_reg) + (RAW_W + 1)'(CAL_MIN_SPAN)
                    < (RAW_W + 1)'(cal_max_x_reg))
              && ((RAW_W + 1)'(cal_min_y_reg) + (RAW_W + 1)'(CAL_MIN_SPAN)
                    < (RAW_W + 1)'(cal_max_y_reg));
        if (axis_reg)
        begin
            raw_sel = raw_y_reg;
            lo_sel = win_ok ? cal_min_y_reg : DEF_CAL_MIN;
            hi_sel = win_ok ? cal_max_y_reg : DEF_CAL_MAX;
            top_sel = TOP_Y;
        end
        else
        begin
            raw_sel = raw_x_reg;
            lo_sel = win_ok ? cal_min_x_reg : DEF_CAL_MIN;
            hi_sel = win_ok ? cal_max_x_reg : DEF_CAL_MAX;
            top_sel = TOP_X;
        end
        below_win = (raw_sel <= lo_sel);
        product = NUM_W'(raw_sel - lo_sel) * NUM_W'(top_sel);
        span = hi_sel - lo_sel;
        div_start = (state_reg == ST_MAP) && !below_win;
        quot_clamped = (div_quot > NUM_W'(top_sel)) ? top_sel : TW'(div_quot);
    end

    // Shared divider, run at most once per axis; an axis at or below the window's low edge skips it.
    tzec_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (product),
        .denom (span),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Zone classification of the mapped point.
    always_comb
    begin
        if (CW'(y_reg) >= CW'(footer_top_row_reg))
        begin
            if (CW'(x_reg) < CW'(ZONE_PREV_END))
            begin
                ev_class = EV_PREV;
            end
            else if (CW'(x_reg) < CW'(ZONE_SEL_END))
            begin
                ev_class = EV_SELECT;
            end
            else
            begin
                ev_class = EV_NEXT;
            end
        end
        else if ((CW'(x_reg) < CW'(BACK_COL_END)) && (CW'(y_reg) < CW'(header_rows_reg)))
        begin
            ev_class = EV_BACK;
        end
        else
        begin
            ev_class = EV_NONE;
        end
    end

    // Sequencer, configuration registers, press state and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg <= 1'b0;
            cal_min_x_reg <= DEF_CAL_MIN;
            cal_max_x_reg <= DEF_CAL_MAX;
            cal_min_y_reg <= DEF_CAL_MIN;
            cal_max_y_reg <= DEF_CAL_MAX;
            footer_top_row_reg <= DEF_FOOTER_TOP_ROW;
            header_rows_reg <= DEF_HEADER_ROWS;
            holdoff_ms_reg <= DEF_HOLDOFF_MS;
            press_latched_reg <= 1'b0;
            last_event_time_reg <= '0;
            raw_x_reg <= '0;
            raw_y_reg <= '0;
            x_reg <= '0;
            y_reg <= '0;
            out_valid_reg <= 1'b0;
            event_res_reg <= EV_NONE;
            screen_x_reg <= '0;
            screen_y_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // Configuration writes; calibration changes drop the press latch.
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CAL_MIN_X:
                    begin
                        cal_min_x_reg <= cfg_data[RAW_W-1:0];
                        press_latched_reg <= 1'b0;
                    end
                    REG_CAL_MAX_X:
                    begin
                        cal_max_x_reg <= cfg_data[RAW_W-1:0];
                        press_latched_reg <= 1'b0;
                    end
                    REG_CAL_MIN_Y:
                    begin
                        cal_min_y_reg <= cfg_data[RAW_W-1:0];
                        press_latched_reg <= 1'b0;
                    end
                    REG_CAL_MAX_Y:
                    begin
                        cal_max_y_reg <= cfg_data[RAW_W-1:0];
                        press_latched_reg <= 1'b0;
                    end
                    REG_FOOTER_TOP_ROW: footer_top_row_reg <= cfg_data[ROW_W-1:0];
                    REG_HEADER_ROWS:    header_rows_reg <= cfg_data[ROW_W-1:0];
                    REG_HOLDOFF_MS:     holdoff_ms_reg <= cfg_data[HOLD_W-1:0];
                    default:            ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (touched && press_ok)
                        begin
                            press_latched_reg <= 1'b1;
                            last_event_time_reg <= now_ms;
                            raw_x_reg <= raw_x;
                            raw_y_reg <= raw_y;
                            axis_reg <= 1'b0;
                            state_reg <= ST_MAP;
                        end
                        else
                        begin
                            if (!touched)
                            begin
                                press_latched_reg <= 1'b0;
                            end
                            out_valid_reg <= 1'b1;
                            event_res_reg <= EV_NONE;
                            screen_x_reg <= '0;
                            screen_y_reg <= '0;
                        end
                    end
                end
                ST_MAP:
                begin
                    if (below_win)
                    begin
                        if (axis_reg)
                        begin
                            y_reg <= '0;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            x_reg <= '0;
                            axis_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        if (axis_reg)
                        begin
                            y_reg <= YW'(quot_clamped);
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            x_reg <= XW'(quot_clamped);
                            axis_reg <= 1'b1;
                            state_reg <= ST_MAP;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        event_res_reg <= ev_class;
                        screen_x_reg <= SX_W'(x_reg);
                        screen_y_reg <= SY_W'(y_reg);
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign event_res = event_res_reg;
    assign screen_x = screen_x_reg;
    assign screen_y = screen_y_reg;

endmodule

`default_nettype wire

[test/touch_zone_event_classifier_tb.sv]
`timescale 1ns / 1ps

module touch_zone_event_classifier_tb;
    import tzec_pkg::*;

    localparam int SCR_MAX_X = 319;
    localparam int SCR_MAX_Y = 239;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_SAMPLES = 75;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // One output transaction: the event code and the mapped screen point.
    typedef struct packed {
        logic [EV_W-1:0] ev;
        logic [SX_W-1:0] col;
        logic [SY_W-1:0] row;
    } touch_event_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic in_valid = 1'b0;
    logic in_stall;
    logic touched = 1'b0;
    logic [RAW_W-1:0] raw_x = '0;
    logic [RAW_W-1:0] raw_y = '0;
    logic [TIME_W-1:0] now_ms = '0;

    logic out_valid;
    logic out_stall = 1'b0;
    logic [EV_W-1:0] event_res;
    logic [SX_W-1:0] screen_x;
    logic [SY_W-1:0] screen_y;

    // Shadow copy of the register file and the press state.
    logic [RAW_W-1:0] win_min_x = DEF_CAL_MIN;
    logic [RAW_W-1:0] win_max_x = DEF_CAL_MAX;
    logic [RAW_W-1:0] win_min_y = DEF_CAL_MIN;
    logic [RAW_W-1:0] win_max_y = DEF_CAL_MAX;
    logic [ROW_W-1:0] footer_row = DEF_FOOTER_TOP_ROW;
    logic [ROW_W-1:0] header_band = DEF_HEADER_ROWS;
    logic [HOLD_W-1:0] hold_ms = DEF_HOLDOFF_MS;
    logic latched = 1'b0;
    logic [TIME_W-1:0] last_press_ms = '0;

    touch_event_t pending_events[$];
    logic [TIME_W-1:0] stamp_ms = 32'd1000;
    logic quiet = 1'b0;
    int unsigned stall_left = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    touch_zone_event_classifier #(
        .SCREEN_MAX_X(SCR_MAX_X),
        .SCREEN_MAX_Y(SCR_MAX_Y)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .touched(touched),
        .raw_x(raw_x),
        .raw_y(raw_y),
        .now_ms(now_ms),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .event_res(event_res),
        .screen_x(screen_x),
        .screen_y(screen_y)
    );

    always #2 clk = ~clk;

    // Linear map of one raw reading onto 0..top, truncated and clamped.
    function automatic int unsigned scale_axis(input logic [RAW_W-1:0] raw,
                                               input logic [RAW_W-1:0] lo,
                                               input logic [RAW_W-1:0] hi,
                                               input int unsigned top);
        int unsigned num;
        int unsigned den;
        int unsigned q;
        if (raw <= lo)
            return 0;
        num = raw;
        num = num - lo;
        den = hi;
        den = den - lo;
        q = (num * top) / den;
        return (q > top) ? top : q;
    endfunction

    // Works out the event for one sample and advances the shadow press state.
    function automatic touch_event_t classify_sample(input logic hit,
                                                     input logic [RAW_W-1:0] rx,
                                                     input logic [RAW_W-1:0] ry,
                                                     input logic [TIME_W-1:0] ms);
        touch_event_t r;
        logic [TIME_W-1:0] elapsed;
        int unsigned lo_x;
        int unsigned hi_x;
        int unsigned lo_y;
        int unsigned hi_y;
        int unsigned px;
        int unsigned py;
        r = '0;
        if (!hit) begin
            latched = 1'b0;
            return r;
        end
        elapsed = ms - last_press_ms;
        if (latched || elapsed < 32'(hold_ms))
            return r;

        // Fall back to the default window when either span is too narrow.
        lo_x = DEF_CAL_MIN;
        hi_x = DEF_CAL_MAX;
        lo_y = DEF_CAL_MIN;
        hi_y = DEF_CAL_MAX;
        if (32'(win_min_x) + 32'(CAL_MIN_SPAN) < 32'(win_max_x)
                && 32'(win_min_y) + 32'(CAL_MIN_SPAN) < 32'(win_max_y)) begin
            lo_x = win_min_x;
            hi_x = win_max_x;
            lo_y = win_min_y;
            hi_y = win_max_y;
        end
        px = scale_axis(rx, RAW_W'(lo_x), RAW_W'(hi_x), SCR_MAX_X);
        py = scale_axis(ry, RAW_W'(lo_y), RAW_W'(hi_y), SCR_MAX_Y);
        latched = 1'b1;
        last_press_ms = ms;

        if (py >= footer_row) begin
            if (px < ZONE_PREV_END)
                r.ev = EV_PREV;
            else if (px < ZONE_SEL_END)
                r.ev = EV_SELECT;
            else
                r.ev = EV_NEXT;
        end else if (px < BACK_COL_END && py < header_band) begin
            r.ev = EV_BACK;
        end else begin
            r.ev = EV_NONE;
        end
        r.col = px[SX_W-1:0];
        r.row = py[SY_W-1:0];
        return r;
    endfunction

    // Predicts each accepted sample, checks each accepted result and paces out_stall.
    always @(posedge clk) begin
        touch_event_t want;
        touch_event_t got;
        if (in_valid && !in_stall)
            pending_events.push_back(classify_sample(touched, raw_x, raw_y, now_ms));
        if (out_valid && !out_stall) begin
            got.ev = event_res;
            got.col = screen_x;
            got.row = screen_y;
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected result event %0d x %0d y %0d",
                         $time, got.ev, got.col, got.row);
                fail_count++;
            end else begin
                want = pending_events.pop_front();
                if (got !== want) begin
                    $display("%0t: expected event %0d x %0d y %0d, got event %0d x %0d y %0d",
                             $time, want.ev, want.col, want.row, got.ev, got.col, got.row);
                    fail_count++;
                end
            end
            stall_left = quiet ? 0 : $urandom_range(0, 4);
            out_stall <= (stall_left != 0);
        end else if (stall_left != 0) begin
            stall_left--;
            out_stall <= (stall_left != 0);
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offers one sample after a random gap and returns once it is accepted.
    task automatic send_sample(input logic hit, input logic [RAW_W-1:0] rx,
                               input logic [RAW_W-1:0] ry, input logic [TIME_W-1:0] ms);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        touched <= hit;
        raw_x <= rx;
        raw_y <= ry;
        now_ms <= ms;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drops valid and waits until every predicted result has been checked.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0)
            @(posedge clk);
    endtask

    // One register write; write enable drops again before the task returns, keeping write enables apart.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CAL_MIN_X:
            begin
                win_min_x = value[RAW_W-1:0];
                latched = 1'b0;
            end
            REG_CAL_MAX_X:
            begin
                win_max_x = value[RAW_W-1:0];
                latched = 1'b0;
            end
            REG_CAL_MIN_Y:
            begin
                win_min_y = value[RAW_W-1:0];
                latched = 1'b0;
            end
            REG_CAL_MAX_Y:
            begin
                win_max_y = value[RAW_W-1:0];
                latched = 1'b0;
            end
            REG_FOOTER_TOP_ROW: footer_row = value[ROW_W-1:0];
            REG_HEADER_ROWS: header_band = value[ROW_W-1:0];
            REG_HOLDOFF_MS: hold_ms = value;
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    // Writes the whole register file, with junk in the unused upper data bits.
    task automatic program_regs(input logic [RAW_W-1:0] lx, input logic [RAW_W-1:0] hx,
                                input logic [RAW_W-1:0] ly, input logic [RAW_W-1:0] hy,
                                input logic [ROW_W-1:0] footer, input logic [ROW_W-1:0] header,
                                input logic [HOLD_W-1:0] hold);
        wait_idle();
        write_reg(REG_CAL_MIN_X, {4'($urandom), lx});
        write_reg(REG_CAL_MAX_X, {4'($urandom), hx});
        write_reg(REG_CAL_MIN_Y, {4'($urandom), ly});
        write_reg(REG_CAL_MAX_Y, {4'($urandom), hy});
        write_reg(REG_FOOTER_TOP_ROW, {8'($urandom), footer});
        write_reg(REG_HEADER_ROWS, {8'($urandom), header});
        write_reg(REG_HOLDOFF_MS, hold);
        write_reg(REG_UNUSED, 16'($urandom));
    endtask

    // Release, then a press late enough to clear the hold-off.
    task automatic tap(input logic [RAW_W-1:0] rx, input logic [RAW_W-1:0] ry);
        stamp_ms += 1;
        send_sample(1'b0, RAW_W'($urandom), RAW_W'($urandom), stamp_ms);
        stamp_ms += 32'(hold_ms);
        send_sample(1'b1, rx, ry, stamp_ms);
    endtask

    // A release, a press that is sometimes too early, and a few held samples.
    task automatic press_gesture(output int unsigned count);
        int unsigned holds;
        logic [RAW_W-1:0] px;
        logic [RAW_W-1:0] py;
        logic [TIME_W-1:0] lead;
        px = RAW_W'($urandom_range(0, 4095));
        py = RAW_W'($urandom_range(0, 4095));
        stamp_ms += $urandom_range(1, 30);
        send_sample(1'b0, RAW_W'($urandom), RAW_W'($urandom), stamp_ms);
        lead = 32'(hold_ms) + $urandom_range(0, 40);
        if ($urandom_range(0, 7) == 0 && hold_ms != 0)
            lead = $urandom_range(0, hold_ms - 1);
        stamp_ms += lead;
        send_sample(1'b1, px, py, stamp_ms);
        holds = $urandom_range(0, 3);
        repeat (holds) begin
            stamp_ms += $urandom_range(1, 20);
            send_sample(1'b1, px + RAW_W'($urandom_range(0, 7)),
                        py + RAW_W'($urandom_range(0, 7)), stamp_ms);
        end
        count = holds + 2;
    endtask

    // Every zone and both window edges under the reset settings.
    task automatic test_zone_mapping();
        tap(12'd0, 12'd0);
        tap(12'd201, 12'd3800);
        tap(12'd2000, 12'd4095);
        tap(12'd4095, 12'd3799);
        tap(12'd2000, 12'd2000);
    endtask

    // Hold-off edges, the press latch, timestamp wrap and latch clearing by writes.
    task automatic test_holdoff_latch();
        logic [TIME_W-1:0] t0;
        tap(12'd1000, 12'd1000);
        t0 = stamp_ms;
        send_sample(1'b1, 12'd1500, 12'd1500, t0 + 32'd200);
        send_sample(1'b0, 12'd0, 12'd0, t0 + 32'd10);
        send_sample(1'b1, 12'd3000, 12'd3900, t0 + 32'(hold_ms) - 32'd1);
        send_sample(1'b1, 12'd3000, 12'd3900, t0 + 32'(hold_ms));
        send_sample(1'b0, 12'hFFF, 12'hFFF, t0 + 32'd100);

        // Elapsed time across the 32-bit wrap, one short and one exact.
        send_sample(1'b1, 12'd600, 12'd600, 32'hFFFF_FFF0);
        send_sample(1'b0, 12'd0, 12'd0, 32'hFFFF_FFF8);
        send_sample(1'b1, 12'd600, 12'd600, 32'h0000_0049);
        send_sample(1'b1, 12'd600, 12'd600, 32'h0000_004A);

        // A calibration write releases the latch; an unknown index does not.
        wait_idle();
        write_reg(REG_CAL_MIN_X, 16'(DEF_CAL_MIN));
        send_sample(1'b1, 12'd700, 12'd700, 32'd400);
        wait_idle();
        write_reg(REG_UNUSED, 16'hFFFF);
        send_sample(1'b1, 12'd700, 12'd700, 32'd900);
        stamp_ms = 32'd2000;
    endtask

    // Full-range window, narrowest window, and a window that fails the span check.
    task automatic test_register_settings();
        program_regs(12'd0, 12'd4095, 12'd0, 12'd4095, 8'd0, 8'd239, 16'd0);
        tap(12'd4095, 12'd0);
        program_regs(12'd3894, 12'd4095, 12'd3894, 12'd4095, 8'd239, 8'd0, 16'hFFFF);
        tap(12'd4000, 12'd4095);
        program_regs(12'd1000, 12'd1200, 12'd4095, 12'd0, 8'd210, 8'd30, 16'd90);
        tap(12'd3800, 12'd200);
    endtask

    // Phases of random settings, mostly press gestures with some raw noise.
    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned n;
        int unsigned lx;
        int unsigned hx;
        int unsigned ly;
        int unsigned hy;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if ($urandom_range(0, 3) == 0) begin
                lx = $urandom_range(0, 4095);
                hx = $urandom_range(0, 4095);
                ly = $urandom_range(0, 4095);
                hy = $urandom_range(0, 4095);
            end else begin
                lx = $urandom_range(0, 3894);
                hx = $urandom_range(lx + 201, 4095);
                ly = $urandom_range(0, 3894);
                hy = $urandom_range(ly + 201, 4095);
            end
            program_regs(RAW_W'(lx), RAW_W'(hx), RAW_W'(ly), RAW_W'(hy),
                         ROW_W'($urandom_range(100, 239)), ROW_W'($urandom_range(0, 120)),
                         ($urandom_range(0, 3) == 0) ? HOLD_W'($urandom)
                                                     : HOLD_W'($urandom_range(0, 300)));
            quiet = (ph == 1) || ($urandom_range(0, 4) == 0);
            stamp_ms = $urandom();
            sent = 0;
            while (sent < PHASE_SAMPLES) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_sample(1'($urandom), RAW_W'($urandom), RAW_W'($urandom), $urandom());
                    sent++;
                end else begin
                    press_gesture(n);
                    sent += n;
                end
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zone_mapping();
        test_holdoff_latch();
        test_register_settings();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
